// ----- sv/ssod_pkg.sv -----
// Shared types and constants for the scan segment object detector.
`timescale 1ns / 1ps
`default_nettype none

package ssod_pkg;

	localparam int MAX_SWEEP_SAMPLES = 256;
	localparam int ANG_W             = 8;
	localparam int DIST_W            = 16;
	localparam int SUM_W             = 24;
	localparam int CNT_W             = $clog2(MAX_SWEEP_SAMPLES + 1);
	localparam int NUM_W             = 8;
	localparam int DIV_STEPS         = SUM_W;
	localparam int DIV_CNT_W         = $clog2(DIV_STEPS);

	localparam logic [CNT_W-1:0]     RUN_MAX      = CNT_W'(MAX_SWEEP_SAMPLES);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST     = DIV_CNT_W'(DIV_STEPS - 1);
	localparam logic [NUM_W-1:0]     OBJ_SAT      = '1;
	localparam logic [DIST_W-1:0]    THR_RESET    = 16'd160;
	localparam logic [DIST_W-1:0]    LIMIT_RESET  = 16'd2160;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_JUMP_THRESHOLD = 1'b0,
		REG_OBJECT_LIMIT   = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HELD,
		S_CHECK,
		S_UPDATE,
		S_LOAD,
		S_DIV,
		S_MERGE,
		S_FINAL,
		S_EMIT
	} state_t;

	// one section report
	typedef struct packed {
		logic [NUM_W-1:0]  object_number;
		logic              is_object;
		logic              sweep_done;
		logic [DIST_W-1:0] section_distance;
		logic [ANG_W-1:0]  mid_angle;
		logic [ANG_W-1:0]  width;
		logic [ANG_W-1:0]  end_angle;
		logic [ANG_W-1:0]  start_angle;
	} res_t;

endpackage

`default_nettype wire

// ----- sv/scan_segment_object_detector.sv -----
// Scan segment object detector: run splitting, serial averaging, section reports.
// A sample that closes no run passes the accept, check and update states.
// A run closure adds divider load, 24 one-bit restoring division steps and
// merge; each section report adds an emit state that may wait on an output stall,
// the final section a setup state before it, a held report a release state.
// The worst case is a jump plus a final sample with three reports.
// Throughput is set by the shared one-bit-per-cycle divider; one sample in flight.
// arst_n clears the sequencer, run, pending section and hold, and restores the configuration defaults.
`timescale 1ns / 1ps
`default_nettype none

module scan_segment_object_detector
	import ssod_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// sample requests
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // [7:0] angle, [23:8] distance
	input  wire logic        s_tlast,   // last_sample
	// section reports
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [7:0] start_angle, [15:8] end_angle, [23:16] width, [31:24] mid_angle,
	// [47:32] section_distance, [55:48] object_number
	output logic [55:0]      m_tdata,
	output logic             m_tuser,   // is_object
	output logic             m_tlast,   // sweep_done
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	state_t state_q, state_d;

	// configuration
	logic [DIST_W-1:0] jump_threshold_q;
	logic [DIST_W-1:0] object_limit_q;

	// captured sample
	logic [ANG_W-1:0]  in_angle_q;
	logic [DIST_W-1:0] in_dist_q;
	logic              in_last_q;

	// run and section state
	logic [DIST_W-1:0] run_first_value_q;
	logic [ANG_W-1:0]  run_first_angle_q;
	logic [SUM_W-1:0]  run_sum_q;
	logic [CNT_W-1:0]  run_count_q;
	logic              pending_valid_q;
	logic [ANG_W-1:0]  pending_start_q;
	logic [DIST_W-1:0] pending_dist_q;
	logic [NUM_W-1:0]  objects_seen_q;

	// close_run caller: 0 = jump during the sample, 1 = end of sweep
	logic              phase_q;
	// reports issued for the current sample, third goes to the hold
	logic [1:0]        res_n_q;

	// section waiting to be reported
	logic [ANG_W-1:0]  em_start_q;
	logic [ANG_W-1:0]  em_end_q;
	logic [DIST_W-1:0] em_dist_q;
	logic              em_done_q;

	// hold for a third report, and the output register
	logic              held_valid_q;
	res_t              held_q;
	logic              out_valid_q;
	res_t              out_q;

	// shared restoring divider
	logic [SUM_W-1:0]     div_num_q;
	logic [CNT_W-1:0]     div_den_q;
	logic [CNT_W-1:0]     div_rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	// ------------------------------------------------------------------
	// combinational datapath
	// ------------------------------------------------------------------
	logic [DIST_W-1:0] dist_diff;
	logic              close_jump;
	logic [CNT_W:0]    div_trial;
	logic              div_ge;
	logic [CNT_W:0]    div_sub;
	logic [DIST_W-1:0] avg;
	logic              new_section;
	logic [NUM_W-1:0]  seen_next;
	res_t              em_res;
	logic              out_free;
	logic              emit_fire;
	logic              out_load;

	assign dist_diff  = (in_dist_q > run_first_value_q) ? (in_dist_q - run_first_value_q)
	                                                    : (run_first_value_q - in_dist_q);
	assign close_jump = (run_count_q != '0) &&
	                    ((dist_diff > jump_threshold_q) || (run_count_q >= RUN_MAX));

	assign div_trial = {div_rem_q, div_num_q[SUM_W-1]};
	assign div_ge    = (div_trial >= {1'b0, div_den_q});
	assign div_sub   = div_trial - {1'b0, div_den_q};

	// quotient is complete in div_num_q once the last step has run
	assign avg         = div_num_q[DIST_W-1:0];
	assign new_section = !(pending_valid_q && (pending_dist_q == avg));

	assign out_free  = !out_valid_q || m_tready;
	// the third report of a sample never waits: it parks in the hold
	assign emit_fire = (res_n_q == 2'd2) || out_free;
	// output register takes the held report or a fresh one
	assign out_load  = ((state_q == S_HELD) && out_free) ||
	                   ((state_q == S_EMIT) && emit_fire && (res_n_q != 2'd2));

	always_comb begin
		em_res                  = '0;
		em_res.start_angle      = em_start_q;
		em_res.end_angle        = em_end_q;
		em_res.width            = em_end_q - em_start_q;
		em_res.mid_angle        = (em_res.width >> 1) + em_start_q;
		em_res.section_distance = em_dist_q;
		em_res.is_object        = (em_dist_q < object_limit_q);
		em_res.sweep_done       = em_done_q;
		seen_next               = objects_seen_q;
		if (em_res.is_object) begin
			if (objects_seen_q != OBJ_SAT) begin
				seen_next = objects_seen_q + 1'b1;
			end
			em_res.object_number = seen_next;
		end
	end

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = held_valid_q ? S_HELD : S_CHECK;
				end
			end
			S_HELD: begin
				if (out_free) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK:  state_d = close_jump ? S_LOAD : S_UPDATE;
			S_UPDATE: state_d = in_last_q ? S_LOAD : S_IDLE;
			S_LOAD:   state_d = S_DIV;
			S_DIV: begin
				if (div_cnt_q == DIV_LAST) begin
					state_d = S_MERGE;
				end
			end
			S_MERGE: begin
				if (new_section && pending_valid_q) begin
					state_d = S_EMIT;
				end else begin
					state_d = phase_q ? S_FINAL : S_UPDATE;
				end
			end
			S_FINAL: state_d = pending_valid_q ? S_EMIT : S_IDLE;
			S_EMIT: begin
				if (emit_fire) begin
					if (em_done_q) begin
						state_d = S_IDLE;
					end else begin
						state_d = phase_q ? S_FINAL : S_UPDATE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = (state_q == S_IDLE);
		cfg_ready = 1'b1;
		m_tvalid  = out_valid_q;
		m_tdata   = {out_q.object_number, out_q.section_distance, out_q.mid_angle,
		             out_q.width, out_q.end_angle, out_q.start_angle};
		m_tuser   = out_q.is_object;
		m_tlast   = out_q.sweep_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// control and model state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_threshold_q  <= THR_RESET;
			object_limit_q    <= LIMIT_RESET;
			run_first_value_q <= '0;
			run_first_angle_q <= '0;
			run_sum_q         <= '0;
			run_count_q       <= '0;
			pending_valid_q   <= 1'b0;
			pending_start_q   <= '0;
			pending_dist_q    <= '0;
			objects_seen_q    <= '0;
			phase_q           <= 1'b0;
			res_n_q           <= '0;
			held_valid_q      <= 1'b0;
			out_valid_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (reg_idx_t'(cfg_index))
					REG_JUMP_THRESHOLD: jump_threshold_q <= cfg_data;
					REG_OBJECT_LIMIT:   object_limit_q   <= cfg_data;
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					res_n_q <= '0;
				end
				S_HELD: begin
					if (out_free) begin
						held_valid_q <= 1'b0;
						res_n_q      <= 2'd1;
					end
				end
				S_CHECK: begin
					phase_q <= 1'b0;
				end
				S_UPDATE: begin
					if (run_count_q == '0) begin
						run_first_value_q <= in_dist_q;
						run_first_angle_q <= in_angle_q;
						run_sum_q         <= SUM_W'(in_dist_q);
						run_count_q       <= CNT_W'(1);
					end else begin
						run_sum_q   <= run_sum_q + SUM_W'(in_dist_q);
						run_count_q <= run_count_q + 1'b1;
					end
					phase_q <= 1'b1;
				end
				S_MERGE: begin
					if (new_section) begin
						pending_valid_q <= 1'b1;
						pending_start_q <= run_first_angle_q;
						pending_dist_q  <= avg;
					end
					run_count_q <= '0;
					run_sum_q   <= '0;
				end
				S_FINAL: begin
					if (!pending_valid_q) begin
						objects_seen_q <= '0;
					end
				end
				S_EMIT: begin
					if (emit_fire) begin
						if (res_n_q == 2'd2) begin
							held_valid_q <= 1'b1;
						end else begin
							res_n_q <= res_n_q + 1'b1;
						end
						if (em_done_q) begin
							objects_seen_q  <= '0;
							pending_valid_q <= 1'b0;
						end else begin
							objects_seen_q <= seen_next;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_angle_q <= s_tdata[ANG_W-1:0];
			in_dist_q  <= s_tdata[ANG_W+DIST_W-1:ANG_W];
			in_last_q  <= s_tlast;
		end

		case (state_q)
			S_HELD: begin
				if (out_free) begin
					out_q <= held_q;
				end
			end
			S_LOAD: begin
				div_num_q <= run_sum_q;
				div_den_q <= run_count_q;
				div_rem_q <= '0;
				div_cnt_q <= '0;
			end
			S_DIV: begin
				div_rem_q <= div_ge ? div_sub[CNT_W-1:0] : div_trial[CNT_W-1:0];
				div_num_q <= {div_num_q[SUM_W-2:0], div_ge};
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			S_MERGE: begin
				// the report closes at the new run's first angle
				em_start_q <= pending_start_q;
				em_end_q   <= run_first_angle_q;
				em_dist_q  <= pending_dist_q;
				em_done_q  <= 1'b0;
			end
			S_FINAL: begin
				em_start_q <= pending_start_q;
				em_end_q   <= in_angle_q;
				em_dist_q  <= pending_dist_q;
				em_done_q  <= 1'b1;
			end
			S_EMIT: begin
				if (emit_fire) begin
					if (res_n_q == 2'd2) begin
						held_q <= em_res;
					end else begin
						out_q <= em_res;
					end
				end
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		run_count_q <= RUN_MAX)
		else $error("run count beyond sweep limit");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_rem_q < div_den_q))
		else $error("divider remainder not below divisor");

	a_one_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second sample taken while busy");

	a_sweep_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && emit_fire && em_done_q) |=>
		(!pending_valid_q && objects_seen_q == '0 && run_count_q == '0))
		else $error("sweep state not cleared after final section");

	a_hold_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && res_n_q == 2'd2) |-> !held_valid_q)
		else $error("hold overwritten before delivery");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the scan segment object detector.
`timescale 1ns / 1ps

module testbench;
	import ssod_pkg::*;

	localparam int LATENCY_CYCLES = 100;   // margin for the worst sample, one with three reports
	localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake on any channel

	typedef enum int {SPREAD_CLUSTER, SPREAD_NEAR_LIMIT, SPREAD_WILD} spread_t;

	// directed probe: one sample, optionally with its single report typed in
	typedef struct {
		logic [7:0]  angle;
		logic [15:0] distance;
		logic        last;
		bit          typed;
		res_t        want;
	} probe_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;   // [7:0] angle, [23:8] distance
	logic        s_tlast   = 1'b0; // last_sample
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [55:0] m_tdata;          // start, end, width, mid, distance, object number
	logic        m_tuser;          // is_object
	logic        m_tlast;          // sweep_done
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = REG_JUMP_THRESHOLD;
	logic [15:0] cfg_data  = '0;

	always #10 clk = ~clk;

	scan_segment_object_detector DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------
	// Section predictor: own copy of configuration and sweep state
	// ------------------------------------------------------------------
	logic [15:0] jump_thr  = THR_RESET;
	logic [15:0] obj_limit = LIMIT_RESET;

	logic [15:0] run_first_dist = '0;
	logic [7:0]  run_first_ang  = '0;
	logic [23:0] run_total      = '0;
	logic [8:0]  run_len        = '0;
	logic        sect_open      = 1'b0;  // a section waits for its end angle
	logic [7:0]  sect_start     = '0;
	logic [15:0] sect_dist      = '0;
	logic [7:0]  objects_seen   = '0;

	res_t expected_sections[$];
	int   step_sections;
	// three reports on a final sample: the block may keep the third one back
	// until the next request arrives, so a spare request is sent before waiting
	bit   third_report_held = 1'b0;

	int   error_count  = 0;
	int   samples_sent = 0;
	int   next_gap     = 0;
	bit   steady       = 1'b0;  // no idling on either side

	function automatic void add_section(logic [7:0] first_ang, logic [7:0] end_ang,
	                                    logic [15:0] distance, logic done);
		res_t r;
		r.start_angle      = first_ang;
		r.end_angle        = end_ang;
		r.width            = end_ang - first_ang;
		r.mid_angle        = (r.width >> 1) + first_ang;
		r.section_distance = distance;
		r.is_object        = distance < obj_limit;
		r.object_number    = '0;
		if (r.is_object) begin
			if (objects_seen != OBJ_SAT)
				objects_seen++;
			r.object_number = objects_seen;
		end
		r.sweep_done = done;
		expected_sections.push_back(r);
		step_sections++;
	endfunction

	// average the open run; a new average opens a section and closes the old one
	function automatic void end_run();
		logic [23:0] quotient;
		logic [15:0] avg;
		if (run_len == 0)
			return;
		quotient = run_total / run_len;
		avg      = quotient[15:0];
		if (!(sect_open && sect_dist == avg)) begin
			if (sect_open)
				add_section(sect_start, run_first_ang, sect_dist, 1'b0);
			sect_open  = 1'b1;
			sect_start = run_first_ang;
			sect_dist  = avg;
		end
		run_len   = '0;
		run_total = '0;
	endfunction

	function automatic void segment_sample(logic [7:0] ang, logic [15:0] distance,
	                                       logic last);
		logic [15:0] dev;
		step_sections = 0;
		if (run_len != 0) begin
			dev = (distance > run_first_dist) ? distance - run_first_dist
			                                  : run_first_dist - distance;
			// jump beyond threshold, or run already full
			if (dev > jump_thr || run_len >= RUN_MAX)
				end_run();
		end
		if (run_len == 0) begin
			run_first_dist = distance;
			run_first_ang  = ang;
			run_total      = {8'd0, distance};
			run_len        = 9'd1;
		end else begin
			run_total = run_total + distance;
			run_len++;
		end
		if (last) begin
			end_run();
			if (sect_open)
				add_section(sect_start, ang, sect_dist, 1'b1);
			sect_open    = 1'b0;
			objects_seen = '0;
			run_len      = '0;
			run_total    = '0;
		end
		third_report_held = (step_sections == 3);
	endfunction

	// ------------------------------------------------------------------
	// Mismatch reporting
	// ------------------------------------------------------------------
	task automatic report_error(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_field(string name, int got, int want);
		if (got != want)
			report_error($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// ------------------------------------------------------------------
	// Sample requests
	// ------------------------------------------------------------------
	// valid stays high across back-to-back requests; it is lowered in the
	// accept step only when a gap follows
	task automatic send_sample(logic [7:0] ang, logic [15:0] distance, logic last);
		repeat (next_gap) @(posedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {distance, ang};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		segment_sample(ang, distance, last);
		samples_sent++;
		next_gap = steady ? 0 : $urandom_range(0, 7);
		if (next_gap != 0)
			s_tvalid <= 1'b0;
	endtask

	// stop sending and wait for every predicted section report
	task automatic settle_results();
		if (third_report_held)
			send_sample(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), 1'b0);
		if (next_gap == 0)
			s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_sections.size() != 0)
			@(posedge clk);
	endtask

	// both registers, back to back, only while the block is idle
	task automatic write_config(logic [15:0] thr, logic [15:0] lim);
		settle_results();
		repeat (LATENCY_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= REG_JUMP_THRESHOLD;
		cfg_data  <= thr;
		do @(posedge clk); while (!cfg_ready);
		jump_thr = thr;
		cfg_index <= REG_OBJECT_LIMIT;
		cfg_data  <= lim;
		do @(posedge clk); while (!cfg_ready);
		obj_limit = lim;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// one sweep with random content; the last sample carries tlast
	task automatic send_sweep(int len);
		spread_t spread;
		int      base;
		int      span;
		int      v;
		int      a;
		int      stride;
		bit      scatter;
		spread  = spread_t'($urandom_range(0, 2));
		scatter = ($urandom_range(0, 7) == 0);  // arbitrary, often decreasing angles
		a       = $urandom_range(0, 200);
		stride  = $urandom_range(0, 4);
		span    = (jump_thr > 1000) ? 1000 : int'(jump_thr);
		if (spread == SPREAD_NEAR_LIMIT)
			base = (obj_limit < 4) ? 0 : int'(obj_limit) - 4;
		else
			base = $urandom_range(0, 65535);
		for (int i = 0; i < len; i++) begin
			case (spread)
				SPREAD_CLUSTER: begin
					if ($urandom_range(0, 4) == 0)
						base = $urandom_range(0, 65535);
					v = base - span + int'($urandom_range(0, 2 * span));
				end
				SPREAD_NEAR_LIMIT: v = base + int'($urandom_range(0, 7));
				default:           v = $urandom_range(0, 65535);
			endcase
			if (v < 0)
				v = 0;
			if (v > 65535)
				v = 65535;
			if (scatter)
				a = $urandom_range(0, 255);
			send_sample(8'(a), 16'(v), i == len - 1);
			if (!scatter)
				a = (a + stride > 255) ? 255 : a + stride;
		end
	endtask

	// ------------------------------------------------------------------
	// Directed probes, run with the reset configuration
	// ------------------------------------------------------------------
	probe_t probes[20] = '{
		// single-sample sweeps: extremes and the object limit boundary
		'{8'd0, 16'd0, 1'b1, 1'b1, '{start_angle: 8'd0, end_angle: 8'd0, width: 8'd0,
			mid_angle: 8'd0, section_distance: 16'd0, is_object: 1'b1,
			object_number: 8'd1, sweep_done: 1'b1}},
		'{8'd255, 16'd65535, 1'b1, 1'b1, '{start_angle: 8'd255, end_angle: 8'd255,
			width: 8'd0, mid_angle: 8'd255, section_distance: 16'd65535, is_object: 1'b0,
			object_number: 8'd0, sweep_done: 1'b1}},
		'{8'd5, 16'd2159, 1'b1, 1'b1, '{start_angle: 8'd5, end_angle: 8'd5, width: 8'd0,
			mid_angle: 8'd5, section_distance: 16'd2159, is_object: 1'b1,
			object_number: 8'd1, sweep_done: 1'b1}},
		'{8'd6, 16'd2160, 1'b1, 1'b1, '{start_angle: 8'd6, end_angle: 8'd6, width: 8'd0,
			mid_angle: 8'd6, section_distance: 16'd2160, is_object: 1'b0,
			object_number: 8'd0, sweep_done: 1'b1}},
		// departure equal to threshold keeps the run, one more closes it;
		// final jump gives three reports on the last sample
		'{8'd10, 16'd1000, 1'b0, 1'b0, '0},
		'{8'd20, 16'd1100, 1'b0, 1'b0, '0},
		'{8'd30, 16'd1160, 1'b0, 1'b0, '0},
		'{8'd40, 16'd1161, 1'b0, 1'b0, '0},
		'{8'd50, 16'd3000, 1'b1, 1'b0, '0},
		// two runs averaging 180 merge into one section
		'{8'd60, 16'd100, 1'b0, 1'b0, '0},
		'{8'd61, 16'd260, 1'b0, 1'b0, '0},
		'{8'd62, 16'd261, 1'b0, 1'b0, '0},
		'{8'd63, 16'd101, 1'b0, 1'b0, '0},
		'{8'd64, 16'd178, 1'b0, 1'b0, '0},
		'{8'd70, 16'd5000, 1'b1, 1'b0, '0},
		// decreasing angle: width and mid wrap
		'{8'd200, 16'd500, 1'b0, 1'b0, '0},
		'{8'd100, 16'd5000, 1'b1, 1'b0, '0},
		// truncated average near full scale
		'{8'd0, 16'd65535, 1'b0, 1'b0, '0},
		'{8'd1, 16'd65534, 1'b0, 1'b0, '0},
		'{8'd2, 16'd65535, 1'b1, 1'b0, '0}
	};

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		logic [15:0] thr;
		logic [15:0] lim;
		logic [15:0] d;
		logic [15:0] prev_d;
		int          phase_start;
		int          len;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probes[i]) begin
			send_sample(probes[i].angle, probes[i].distance, probes[i].last);
			if (probes[i].typed) begin
				repeat (step_sections) void'(expected_sections.pop_back());
				expected_sections.push_back(probes[i].want);
			end
		end

		// threshold 0: every differing sample is its own section and an object,
		// enough of them to saturate the object count
		write_config(16'd0, 16'hFFFF);
		prev_d = '0;
		for (int i = 0; i < 258; i++) begin
			d = 16'($urandom_range(0, 65534));
			if (d == prev_d)
				d = (d == 0) ? 16'd1 : d - 16'd1;
			prev_d = d;
			send_sample(8'(i >> 1), d, i == 257);
		end

		// widest threshold, no objects: a flat run cut at full length then merged;
		// angles wrap past 255
		write_config(16'hFFFF, 16'd0);
		d = 16'($urandom_range(0, 65535));
		for (int i = 0; i < 258; i++)
			send_sample(8'(i), d, i == 257);
		for (int i = 0; i < 3; i++)
			send_sweep($urandom_range(1, 10));

		for (int ph = 0; ph < 3; ph++) begin
			case ($urandom_range(0, 3))
				0:       thr = 16'($urandom_range(0, 3));
				1:       thr = 16'($urandom_range(4, 400));
				2:       thr = 16'($urandom_range(0, 65535));
				default: thr = 16'hFFFF;
			endcase
			case ($urandom_range(0, 3))
				0:       lim = 16'd0;
				1:       lim = 16'hFFFF;
				default: lim = 16'($urandom_range(0, 65535));
			endcase
			write_config(thr, lim);
			steady      = (ph == 1) || ($urandom_range(0, 5) == 0);
			phase_start = samples_sent;
			while (samples_sent - phase_start < 20) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 10);
				send_sweep(len);
				// now and then hold off until the block has caught up
				if ($urandom_range(0, 9) == 0)
					settle_results();
			end
		end

		settle_results();
		repeat (LATENCY_CYCLES) @(posedge clk);
		if (expected_sections.size() != 0)
			report_error($sformatf("%0d section reports never arrived",
			                       expected_sections.size()));
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Section report receiver and checker
	// ------------------------------------------------------------------
	initial begin
		int   stall;
		res_t want;
		wait (arst_n === 1'b1);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			if (expected_sections.size() == 0) begin
				report_error($sformatf("unexpected section report start %0d distance %0d",
				                       m_tdata[7:0], m_tdata[47:32]));
			end else begin
				want = expected_sections.pop_front();
				check_field("start_angle", m_tdata[7:0], want.start_angle);
				check_field("end_angle", m_tdata[15:8], want.end_angle);
				check_field("width", m_tdata[23:16], want.width);
				check_field("mid_angle", m_tdata[31:24], want.mid_angle);
				check_field("section_distance", m_tdata[47:32], want.section_distance);
				check_field("object_number", m_tdata[55:48], want.object_number);
				check_field("is_object", m_tuser, want.is_object);
				check_field("sweep_done", m_tlast, want.sweep_done);
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: cycles without a handshake on any channel
	// ------------------------------------------------------------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
